[src/bdsa_pkg.sv]
package bdsa_pkg;

    // Configuration port geometry.
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 2;

    // Result field widths.
    localparam int PIX_W  = 12;
    localparam int ADDR_W = 26;

    // Default largest image dimension.
    localparam int MAX_DIM_DEFAULT = 4096;

    // Register reset values.
    localparam logic [CFG_W-1:0] LOW_WIDTH_RST   = 13'd1920;
    localparam logic [CFG_W-1:0] HIGH_WIDTH_RST  = 13'd2560;
    localparam logic [CFG_W-1:0] HIGH_HEIGHT_RST = 13'd1440;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOW_WIDTH   = 2'd0,
        CFG_HIGH_WIDTH  = 2'd1,
        CFG_HIGH_HEIGHT = 2'd2
    } cfg_idx_t;

    // Commands from the controller to the datapath.
    typedef enum logic [3:0] {
        OP_NOP,
        OP_ADVANCE,
        OP_GCD_LOAD,
        OP_GCD_COMMON,
        OP_GCD_HALVE_A,
        OP_GCD_REDUCE,
        OP_DIV_LOW_LOAD,
        OP_DIV_HIGH_LOAD,
        OP_DIV_STEP,
        OP_FINISH
    } dp_op_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic both_even;
        logic a_even;
        logic b_zero;
        logic div_last;
        logic adv_ok;
    } dp_status_t;

endpackage

[src/block_diff_scan_address_generator.sv]
// Block-scan address generator for a resolution difference map.
//
// Input channel (s_valid/s_ready, field s_restart): a transaction with
// s_restart high reduces low_width : high_width to lowest terms and yields
// the first scan position; a transaction with s_restart low steps one
// position in block-scan order. Every input transaction yields exactly one
// result transaction on the m_ channel: position, RGBA byte address, keep
// and last flags.
// Advances are taken one per cycle while no restart is in progress and no pending
// result waits behind a stalled output register. An advance's result is held pending
// and enters the output register once that register is free; the scan counters are
// registered and update at the edge that takes the advance. A restart occupies the
// shared GCD/divider datapath: a binary GCD that removes one bit or performs one
// subtraction per cycle, then two restoring divisions of DIM_W-bit dividends, where
// DIM_W = clog2(MAX_DIM+1).
// Reset (aresetn low, synchronous) restores the register defaults, clears
// the factors and the scan position and empties the output register.
// When the receiver holds m_ready low, the result stays in the output
// register, one further result may be staged, and then s_ready drops.
// Configuration writes are taken at any edge with cfg_wr_en high and aresetn high.
module block_diff_scan_address_generator
    import bdsa_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wr_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_restart,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_keep,
    output logic [PIX_W-1:0]     m_pixel_x,
    output logic [PIX_W-1:0]     m_pixel_y,
    output logic [ADDR_W-1:0]    m_byte_address,
    output logic                 m_last
);

    localparam int DIM_W = $clog2(MAX_DIM+1);

    logic [CFG_W-1:0] low_width_reg,   low_width_next;
    logic [CFG_W-1:0] high_width_reg,  high_width_next;
    logic [CFG_W-1:0] high_height_reg, high_height_next;
    logic [DIM_W-1:0] low_dim, wide_dim, tall_dim;

    dp_op_t     op;
    dp_status_t status;

    // A dimension of zero acts as one; one above MAX_DIM acts as MAX_DIM.
    function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (int'(v) > MAX_DIM) begin
            r = DIM_W'(MAX_DIM);
        end else begin
            r = DIM_W'(v);
        end
        return r;
    endfunction

    always_comb begin
        low_width_next   = low_width_reg;
        high_width_next  = high_width_reg;
        high_height_next = high_height_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_LOW_WIDTH:   low_width_next   = cfg_wr_data;
                CFG_HIGH_WIDTH:  high_width_next  = cfg_wr_data;
                CFG_HIGH_HEIGHT: high_height_next = cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_width_reg   <= LOW_WIDTH_RST;
            high_width_reg  <= HIGH_WIDTH_RST;
            high_height_reg <= HIGH_HEIGHT_RST;
        end else begin
            low_width_reg   <= low_width_next;
            high_width_reg  <= high_width_next;
            high_height_reg <= high_height_next;
        end
    end

    // The same clamped dimensions feed the ratio, the scan and the address.
    assign low_dim  = eff_dim(low_width_reg);
    assign wide_dim = eff_dim(high_width_reg);
    assign tall_dim = eff_dim(high_height_reg);

    // The controller sequences restarts and admits advances; the datapath
    // holds the ratio, the scan position and the output register.
    bdsa_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_restart (s_restart),
        .s_ready   (s_ready),
        .status    (status),
        .op        (op)
    );

    bdsa_dp #(
        .MAX_DIM (MAX_DIM)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .op             (op),
        .low_dim        (low_dim),
        .wide_dim       (wide_dim),
        .tall_dim       (tall_dim),
        .status         (status),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_keep         (m_keep),
        .m_pixel_x      (m_pixel_x),
        .m_pixel_y      (m_pixel_y),
        .m_byte_address (m_byte_address),
        .m_last         (m_last)
    );

endmodule

[src/bdsa_ctrl.sv]
module bdsa_ctrl
    import bdsa_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_restart,
    output logic       s_ready,
    input  dp_status_t status,
    output dp_op_t     op
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COMMON,
        ST_HALVE_A,
        ST_REDUCE,
        ST_DIV_LOW,
        ST_LOAD_HIGH,
        ST_DIV_HIGH,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_ready = (state_reg == ST_IDLE) && status.adv_ok;

    always_comb begin
        state_next = state_reg;
        op         = OP_NOP;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    if (s_restart) begin
                        op         = OP_GCD_LOAD;
                        state_next = ST_COMMON;
                    end else begin
                        op = OP_ADVANCE;
                    end
                end
            end
            ST_COMMON: begin
                if (status.both_even) begin
                    op = OP_GCD_COMMON;
                end else begin
                    state_next = ST_HALVE_A;
                end
            end
            ST_HALVE_A: begin
                if (status.a_even) begin
                    op = OP_GCD_HALVE_A;
                end else begin
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE: begin
                if (status.b_zero) begin
                    op         = OP_DIV_LOW_LOAD;
                    state_next = ST_DIV_LOW;
                end else begin
                    op = OP_GCD_REDUCE;
                end
            end
            ST_DIV_LOW: begin
                op = OP_DIV_STEP;
                if (status.div_last) begin
                    state_next = ST_LOAD_HIGH;
                end
            end
            ST_LOAD_HIGH: begin
                op         = OP_DIV_HIGH_LOAD;
                state_next = ST_DIV_HIGH;
            end
            ST_DIV_HIGH: begin
                op = OP_DIV_STEP;
                if (status.div_last) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                op         = OP_FINISH;
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[src/bdsa_dp.sv]
module bdsa_dp
    import bdsa_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  dp_op_t                   op,
    input  logic [$clog2(MAX_DIM+1)-1:0] low_dim,
    input  logic [$clog2(MAX_DIM+1)-1:0] wide_dim,
    input  logic [$clog2(MAX_DIM+1)-1:0] tall_dim,
    output dp_status_t               status,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_keep,
    output logic [PIX_W-1:0]         m_pixel_x,
    output logic [PIX_W-1:0]         m_pixel_y,
    output logic [ADDR_W-1:0]        m_byte_address,
    output logic                     m_last
);

    localparam int DIM_W  = $clog2(MAX_DIM+1);
    localparam int CRD_W  = $clog2(MAX_DIM);
    localparam int EXT_W  = DIM_W + 1;
    localparam int SH_W   = $clog2(DIM_W);
    localparam int CNT_W  = $clog2(DIM_W);
    localparam int SUM_W  = CRD_W + 1;
    localparam int PROD_W = SUM_W + DIM_W;
    localparam int AFUL_W = (PROD_W + 2 > ADDR_W) ? PROD_W + 2 : ADDR_W;

    // Reduced ratio and scan position.
    logic [DIM_W-1:0] big_reg,   big_next;
    logic [DIM_W-1:0] small_reg, small_next;
    logic [CRD_W-1:0] bc_reg, bc_next, br_reg, br_next;
    logic [CRD_W-1:0] oc_reg, oc_next, or_reg, or_next;

    // Binary GCD and divider working registers.
    logic [DIM_W-1:0] ga_reg, ga_next, gb_reg, gb_next;
    logic [SH_W-1:0]  gsh_reg, gsh_next;
    logic [DIM_W-1:0] dd_reg, dd_next, dn_reg, dn_next, dr_reg, dr_next;
    logic [CNT_W-1:0] dcnt_reg, dcnt_next;

    // Output staging.
    logic pend_reg, pend_next;
    logic mv_reg, mv_next;
    logic out_load;
    logic              keep_reg, last_reg;
    logic [PIX_W-1:0]  px_reg, py_reg;
    logic [ADDR_W-1:0] addr_reg;

    // Shared scan geometry.
    logic [EXT_W-1:0] w_e, h_e, bs_e, bc_e, br_e, oc_e, or_e, sf_e;
    logic [EXT_W-1:0] ex_e, ey_e, bc_end, br_end;
    logic             stale;

    // Result terms.
    logic [SUM_W-1:0]  px, py;
    logic [PROD_W-1:0] lin;
    logic [AFUL_W-1:0] addr_full;
    logic              keep_c, last_c;

    // Divider step.
    logic [EXT_W-1:0] rem_sh;
    logic             rem_ge;

    assign w_e  = EXT_W'(wide_dim);
    assign h_e  = EXT_W'(tall_dim);
    assign bs_e = (big_reg == '0) ? EXT_W'(1) : EXT_W'(big_reg);
    assign bc_e = EXT_W'(bc_reg);
    assign br_e = EXT_W'(br_reg);
    assign oc_e = EXT_W'(oc_reg);
    assign or_e = EXT_W'(or_reg);
    assign sf_e = EXT_W'(small_reg);

    assign bc_end = bc_e + bs_e;
    assign br_end = br_e + bs_e;

    // Block extent, clipped to the image.
    assign ex_e = (bc_e >= w_e) ? '0 : (((w_e - bc_e) < bs_e) ? (w_e - bc_e) : bs_e);
    assign ey_e = (br_e >= h_e) ? '0 : (((h_e - br_e) < bs_e) ? (h_e - br_e) : bs_e);
    assign stale = (oc_e >= ex_e) || (or_e >= ey_e);

    assign px = SUM_W'(bc_reg) + SUM_W'(oc_reg);
    assign py = SUM_W'(br_reg) + SUM_W'(or_reg);
    assign lin = PROD_W'(py) * PROD_W'(wide_dim) + PROD_W'(px);
    assign addr_full = AFUL_W'(lin) << 2;

    assign keep_c = ((oc_e >= sf_e) || (or_e >= sf_e))
                    && (EXT_W'(px) < w_e) && (EXT_W'(py) < h_e);
    assign last_c = ((oc_e + EXT_W'(1)) == ex_e) && ((or_e + EXT_W'(1)) == ey_e)
                    && (bc_end >= w_e) && (br_end >= h_e);

    assign rem_sh = {dr_reg, dn_reg[DIM_W-1]};
    assign rem_ge = rem_sh >= EXT_W'(dd_reg);

    assign out_load = pend_reg && (!mv_reg || m_ready);

    assign status.both_even = !ga_reg[0] && !gb_reg[0];
    assign status.a_even    = !ga_reg[0];
    assign status.b_zero    = (gb_reg == '0);
    assign status.div_last  = (dcnt_reg == CNT_W'(DIM_W - 1));
    assign status.adv_ok    = !pend_reg || out_load;

    always_comb begin
        big_next   = big_reg;
        small_next = small_reg;
        bc_next    = bc_reg;
        br_next    = br_reg;
        oc_next    = oc_reg;
        or_next    = or_reg;
        ga_next    = ga_reg;
        gb_next    = gb_reg;
        gsh_next   = gsh_reg;
        dd_next    = dd_reg;
        dn_next    = dn_reg;
        dr_next    = dr_reg;
        dcnt_next  = dcnt_reg;
        pend_next  = out_load ? 1'b0 : pend_reg;
        case (op)
            OP_ADVANCE: begin
                pend_next = 1'b1;
                if (stale) begin
                    bc_next = '0;
                    br_next = '0;
                    oc_next = '0;
                    or_next = '0;
                end else if ((or_e + EXT_W'(1)) < ey_e) begin
                    or_next = or_reg + CRD_W'(1);
                end else begin
                    or_next = '0;
                    if ((oc_e + EXT_W'(1)) < ex_e) begin
                        oc_next = oc_reg + CRD_W'(1);
                    end else begin
                        oc_next = '0;
                        if (bc_end < w_e) begin
                            bc_next = CRD_W'(bc_end);
                        end else begin
                            bc_next = '0;
                            br_next = (br_end < h_e) ? CRD_W'(br_end) : '0;
                        end
                    end
                end
            end
            OP_GCD_LOAD: begin
                ga_next  = low_dim;
                gb_next  = wide_dim;
                gsh_next = '0;
            end
            OP_GCD_COMMON: begin
                ga_next  = ga_reg >> 1;
                gb_next  = gb_reg >> 1;
                gsh_next = gsh_reg + SH_W'(1);
            end
            OP_GCD_HALVE_A: begin
                ga_next = ga_reg >> 1;
            end
            OP_GCD_REDUCE: begin
                if (!gb_reg[0]) begin
                    gb_next = gb_reg >> 1;
                end else if (ga_reg > gb_reg) begin
                    ga_next = gb_reg;
                    gb_next = ga_reg - gb_reg;
                end else begin
                    gb_next = gb_reg - ga_reg;
                end
            end
            OP_DIV_LOW_LOAD: begin
                dd_next   = ga_reg << gsh_reg;
                dn_next   = low_dim;
                dr_next   = '0;
                dcnt_next = '0;
            end
            OP_DIV_HIGH_LOAD: begin
                small_next = dn_reg;
                dn_next    = wide_dim;
                dr_next    = '0;
                dcnt_next  = '0;
            end
            OP_DIV_STEP: begin
                dr_next   = rem_ge ? DIM_W'(rem_sh - EXT_W'(dd_reg)) : DIM_W'(rem_sh);
                dn_next   = {dn_reg[DIM_W-2:0], rem_ge};
                dcnt_next = dcnt_reg + CNT_W'(1);
            end
            OP_FINISH: begin
                big_next  = dn_reg;
                bc_next   = '0;
                br_next   = '0;
                oc_next   = '0;
                or_next   = '0;
                pend_next = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        mv_next = mv_reg;
        if (out_load) begin
            mv_next = 1'b1;
        end else if (m_ready) begin
            mv_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            big_reg   <= '0;
            small_reg <= '0;
            bc_reg    <= '0;
            br_reg    <= '0;
            oc_reg    <= '0;
            or_reg    <= '0;
            pend_reg  <= 1'b0;
            mv_reg    <= 1'b0;
        end else begin
            big_reg   <= big_next;
            small_reg <= small_next;
            bc_reg    <= bc_next;
            br_reg    <= br_next;
            oc_reg    <= oc_next;
            or_reg    <= or_next;
            pend_reg  <= pend_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        ga_reg   <= ga_next;
        gb_reg   <= gb_next;
        gsh_reg  <= gsh_next;
        dd_reg   <= dd_next;
        dn_reg   <= dn_next;
        dr_reg   <= dr_next;
        dcnt_reg <= dcnt_next;
        if (out_load) begin
            keep_reg <= keep_c;
            last_reg <= last_c;
            px_reg   <= PIX_W'(px);
            py_reg   <= PIX_W'(py);
            addr_reg <= addr_full[ADDR_W-1:0];
        end
    end

    assign m_valid        = mv_reg;
    assign m_keep         = keep_reg;
    assign m_pixel_x      = px_reg;
    assign m_pixel_y      = py_reg;
    assign m_byte_address = addr_reg;
    assign m_last         = last_reg;

endmodule

[src/bdsa_checker.sv]
module bdsa_checker
    import bdsa_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              s_restart,
    input logic              m_valid,
    input logic              m_ready,
    input logic              m_keep,
    input logic [PIX_W-1:0]  m_pixel_x,
    input logic [PIX_W-1:0]  m_pixel_y,
    input logic [ADDR_W-1:0] m_byte_address,
    input logic              m_last
);

    // A stalled result holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pixel_x) && $stable(m_pixel_y)
            && $stable(m_byte_address) && $stable(m_keep) && $stable(m_last))
        else $error("stalled result changed");

    // Reset empties the output register.
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // A restart transaction starts the ratio computation, so input stalls.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_restart |=> !s_ready)
        else $error("input taken during ratio computation");

    // Addresses are pixel aligned.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_byte_address[1:0] == 2'b00)
        else $error("byte address not on a pixel boundary");

endmodule

bind block_diff_scan_address_generator bdsa_checker u_bdsa_checker (.*);
